// ----- rtl/phtt_pkg.sv -----
`timescale 1ns / 1ps

package phtt_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Hit shapes.
    localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
    localparam logic [1:0] SHAPE_BOX    = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIZE_TYPE_A = 2'd0;
    localparam logic [1:0] CFG_SIZE_TYPE_B = 2'd1;
    localparam logic [1:0] CFG_SIZE_TYPE_C = 2'd2;

    localparam int OBJ_W  = 258;
    localparam int DATA_W = 264;

    // One stored object, laid out as the stream beat (first field in the low bits).
    typedef struct packed {
        logic [63:0]        payload_two;
        logic [63:0]        payload_one;
        logic signed [31:0] dec_word;
        logic [31:0]        ra_word;
        logic signed [15:0] magnitude;
        logic [9:0]         obj_size;
        logic [1:0]         hit_shape;
        logic [5:0]         obj_type;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } obj_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic query;
        logic scan_rd;
        logic fetch_rd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic have;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/phtt_ctrl.sv -----
`timescale 1ns / 1ps

module phtt_ctrl
    import phtt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        OP_APPEND: begin
                            cmd.append = 1'b1;
                            state_next = ST_EMIT;
                        end
                        OP_QUERY: begin
                            cmd.query  = 1'b1;
                            state_next = sts.count_zero ? ST_EMIT : ST_SCAN;
                        end
                        OP_UNUSED: begin
                            state_next = ST_IDLE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = sts.have ? ST_FETCH : ST_EMIT;
                end
            end
            ST_FETCH: begin
                cmd.fetch_rd = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/phtt_dp.sv -----
`timescale 1ns / 1ps

module phtt_dp
    import phtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int HIT_BORDER  = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] m_tdata,
    output logic [1:0]        m_tuser
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int REACH_W = $clog2(1023 + HIT_BORDER + 1);
    localparam int SQ_W    = 2 * REACH_W;

    // Configuration.
    logic [5:0] type_a_reg, type_b_reg, type_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_a_reg <= 6'd0;
            type_b_reg <= 6'd1;
            type_c_reg <= 6'd2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIZE_TYPE_A: type_a_reg <= cfg_data;
                CFG_SIZE_TYPE_B: type_b_reg <= cfg_data;
                CFG_SIZE_TYPE_C: type_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Object table.
    obj_t mem [TABLE_DEPTH];
    obj_t rd_data_reg;
    obj_t in_obj;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             full_now;

    assign in_obj   = obj_t'(s_tdata[OBJ_W-1:0]);
    assign full_now = (count_reg == CNT_W'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (cmd.append && !full_now) begin
            mem[count_reg[IDX_W-1:0]] <= in_obj;
        end
        if (cmd.scan_rd) begin
            rd_data_reg <= mem[scan_idx_reg];
        end else if (cmd.fetch_rd) begin
            rd_data_reg <= mem[best_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.append && !full_now) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.query) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_rd) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
    end

    // Query point and result kind.
    logic signed [15:0] qx_reg, qy_reg;
    logic               full_reg, query_reg;

    always_ff @(posedge aclk) begin
        if (cmd.query) begin
            qx_reg <= in_obj.pos_x;
            qy_reg <= in_obj.pos_y;
        end
        if (cmd.append || cmd.query) begin
            full_reg  <= cmd.append && full_now;
            query_reg <= cmd.query;
        end
    end

    // Scan pipeline: read, distance, squares, compare.
    logic                v0_reg, v1_reg, v2_reg;
    logic [IDX_W-1:0]    i0_reg, i1_reg, i2_reg;
    logic [15:0]         adx1_reg, ady1_reg;
    logic [REACH_W-1:0]  reach1_reg;
    logic [1:0]          shape1_reg, shape2_reg;
    logic [5:0]          type1_reg, type2_reg;
    logic [9:0]          size1_reg, size2_reg;
    logic signed [15:0]  mag1_reg, mag2_reg;
    logic [31:0]         sqx2_reg, sqy2_reg;
    logic [SQ_W-1:0]     sqr2_reg;
    logic                box2_reg;

    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;

    always_comb begin
        dx  = 17'(qx_reg) - 17'(rd_data_reg.pos_x);
        dy  = 17'(qy_reg) - 17'(rd_data_reg.pos_y);
        adx = dx[16] ? -dx : dx;
        ady = dy[16] ? -dy : dy;
    end

    always_ff @(posedge aclk) begin
        i0_reg     <= scan_idx_reg;
        adx1_reg   <= adx[15:0];
        ady1_reg   <= ady[15:0];
        reach1_reg <= REACH_W'(rd_data_reg.obj_size) + REACH_W'(HIT_BORDER);
        shape1_reg <= rd_data_reg.hit_shape;
        type1_reg  <= rd_data_reg.obj_type;
        size1_reg  <= rd_data_reg.obj_size;
        mag1_reg   <= rd_data_reg.magnitude;
        i1_reg     <= i0_reg;

        sqx2_reg   <= 32'(adx1_reg) * 32'(adx1_reg);
        sqy2_reg   <= 32'(ady1_reg) * 32'(ady1_reg);
        sqr2_reg   <= SQ_W'(reach1_reg) * SQ_W'(reach1_reg);
        box2_reg   <= (adx1_reg <= 16'(reach1_reg)) && (ady1_reg <= 16'(reach1_reg));
        shape2_reg <= shape1_reg;
        type2_reg  <= type1_reg;
        size2_reg  <= size1_reg;
        mag2_reg   <= mag1_reg;
        i2_reg     <= i1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= cmd.scan_rd;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Best-hit tracking.
    logic               have_reg;
    logic [5:0]         best_type_reg;
    logic [9:0]         best_size_reg;
    logic signed [15:0] best_mag_reg;
    logic [32:0]        dist_sq;
    logic               hit;
    logic               size_ranked;
    logic               better;
    logic               take;

    always_comb begin
        dist_sq = 33'(sqx2_reg) + 33'(sqy2_reg);
        unique case (shape2_reg)
            SHAPE_CIRCLE: hit = (dist_sq <= 33'(sqr2_reg));
            SHAPE_BOX:    hit = box2_reg;
            default:      hit = 1'b0;
        endcase
        size_ranked = (type2_reg == type_a_reg) || (type2_reg == type_b_reg)
                   || (type2_reg == type_c_reg);
        if (type2_reg != best_type_reg) begin
            better = type2_reg < best_type_reg;
        end else if (size_ranked) begin
            better = size2_reg < best_size_reg;
        end else begin
            better = mag2_reg < best_mag_reg;
        end
        take = v2_reg && hit && (!have_reg || better);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (cmd.query) begin
            have_reg <= 1'b0;
        end else if (take) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_type_reg <= type2_reg;
            best_size_reg <= size2_reg;
            best_mag_reg  <= mag2_reg;
            best_idx_reg  <= i2_reg;
        end
    end

    // Output register.
    logic m_tvalid_reg;
    logic found;

    assign found = query_reg && have_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tuser <= {full_reg, found};
            m_tdata <= found ? DATA_W'(rd_data_reg) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        sts.count_zero = (count_reg == '0);
        sts.scan_last  = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
        sts.pipe_busy  = v0_reg || v1_reg || v2_reg;
        sts.have       = have_reg;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

// ----- rtl/priority_hit_test_table.sv -----
`timescale 1ns / 1ps
// Clear gives no beat; an append result is loaded into the output register from the EMIT state.
// A query with stored objects runs through the SCAN, DRAIN, FETCH (on a hit only) and EMIT states;
// with an empty table it goes straight to EMIT. The single read port scans one entry per cycle,
// then re-reads the winner. One item at a time; the next is taken once its result is loaded
// into the output register, which waits on a stalled beat. Synchronous active-low reset
// empties the table and output, restores size-ranked types 0, 1, 2; entries are not cleared.
module priority_hit_test_table
    import phtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int HIT_BORDER  = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, obj_type, hit_shape, obj_size, magnitude, ra_word, dec_word,
    // payload_one, payload_two, zero pad
    input  logic [DATA_W-1:0] s_tdata,
    // operation
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // hit_x, hit_y, hit_type, hit_shape_out, hit_size, hit_magnitude, hit_ra, hit_dec,
    // hit_payload_one, hit_payload_two, zero pad
    output logic [DATA_W-1:0] m_tdata,
    // found, table_full
    output logic [1:0]        m_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    phtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    phtt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HIT_BORDER  (HIT_BORDER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/phtt_checker.sv -----
`timescale 1ns / 1ps

module phtt_checker
    import phtt_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A dropped append never reports a hit.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and table_full both set");

    // Without a hit every object field is zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss beat carries object data");

    // Only circles and boxes can be hit.
    a_hit_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[39:38] == SHAPE_CIRCLE) || (m_tdata[39:38] == SHAPE_BOX))
        else $error("hit reported on a shape that never hits");

endmodule

bind priority_hit_test_table phtt_checker u_phtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/priority_hit_test_table_checker.sv -----
`timescale 1ns / 1ps

module priority_hit_test_table_checker
    import phtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int HIT_BORDER  = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    input  logic [1:0]        m_tuser,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data,
    output int unsigned       mismatch_count,
    output int unsigned       pending_count
);

    typedef struct packed {
        logic found;
        logic table_full;
        obj_t hit;
    } pick_t;

    obj_t        objects [TABLE_DEPTH];
    int unsigned stored;
    logic [5:0]  size_type_a;
    logic [5:0]  size_type_b;
    logic [5:0]  size_type_c;
    pick_t       picks_due [$];

    function automatic bit covers(input obj_t o, input logic signed [15:0] qx,
                                  input logic signed [15:0] qy);
        longint dx;
        longint dy;
        longint reach;
        dx = longint'($signed(qx)) - longint'($signed(o.pos_x));
        dy = longint'($signed(qy)) - longint'($signed(o.pos_y));
        reach = longint'(o.obj_size) + HIT_BORDER;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        case (o.hit_shape)
            SHAPE_CIRCLE: return dx * dx + dy * dy <= reach * reach;
            SHAPE_BOX:    return dx <= reach && dy <= reach;
            default:      return 1'b0;
        endcase
    endfunction

    // Strict ordering only, so an equal later entry never displaces the earlier one.
    function automatic bit outranks(input obj_t a, input obj_t b);
        if (a.obj_type != b.obj_type)
            return a.obj_type < b.obj_type;
        if (a.obj_type == size_type_a || a.obj_type == size_type_b ||
            a.obj_type == size_type_c)
            return a.obj_size < b.obj_size;
        return $signed(a.magnitude) < $signed(b.magnitude);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task automatic predict(input logic [1:0] op, input obj_t item);
        pick_t       pick;
        bit          have;
        int unsigned best;
        int unsigned i;
        pick = '0;
        have = 1'b0;
        best = 0;
        case (op)
            OP_CLEAR: stored = 0;
            OP_APPEND: begin
                if (stored >= TABLE_DEPTH) begin
                    pick.table_full = 1'b1;
                end else begin
                    objects[stored] = item;
                    stored++;
                end
                picks_due.push_back(pick);
            end
            OP_QUERY: begin
                for (i = 0; i < stored; i++) begin
                    if (covers(objects[i], item.pos_x, item.pos_y) &&
                        (!have || outranks(objects[i], objects[best]))) begin
                        best = i;
                        have = 1'b1;
                    end
                end
                if (have) begin
                    pick.found = 1'b1;
                    pick.hit   = objects[best];
                end
                picks_due.push_back(pick);
            end
            default: ;
        endcase
    endtask

    task automatic check_pick(input pick_t got);
        pick_t want;
        want = picks_due.pop_front();
        if (got.found !== want.found)
            report("found", 64'(got.found), 64'(want.found));
        if (got.table_full !== want.table_full)
            report("table_full", 64'(got.table_full), 64'(want.table_full));
        if (got.hit.pos_x !== want.hit.pos_x)
            report("hit_x", 64'(got.hit.pos_x), 64'(want.hit.pos_x));
        if (got.hit.pos_y !== want.hit.pos_y)
            report("hit_y", 64'(got.hit.pos_y), 64'(want.hit.pos_y));
        if (got.hit.obj_type !== want.hit.obj_type)
            report("hit_type", 64'(got.hit.obj_type), 64'(want.hit.obj_type));
        if (got.hit.hit_shape !== want.hit.hit_shape)
            report("hit_shape_out", 64'(got.hit.hit_shape), 64'(want.hit.hit_shape));
        if (got.hit.obj_size !== want.hit.obj_size)
            report("hit_size", 64'(got.hit.obj_size), 64'(want.hit.obj_size));
        if (got.hit.magnitude !== want.hit.magnitude)
            report("hit_magnitude", 64'(got.hit.magnitude), 64'(want.hit.magnitude));
        if (got.hit.ra_word !== want.hit.ra_word)
            report("hit_ra", 64'(got.hit.ra_word), 64'(want.hit.ra_word));
        if (got.hit.dec_word !== want.hit.dec_word)
            report("hit_dec", 64'(got.hit.dec_word), 64'(want.hit.dec_word));
        if (got.hit.payload_one !== want.hit.payload_one)
            report("hit_payload_one", got.hit.payload_one, want.hit.payload_one);
        if (got.hit.payload_two !== want.hit.payload_two)
            report("hit_payload_two", got.hit.payload_two, want.hit.payload_two);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            stored      = 0;
            size_type_a = 6'd0;
            size_type_b = 6'd1;
            size_type_c = 6'd2;
            picks_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SIZE_TYPE_A: size_type_a = cfg_data;
                    CFG_SIZE_TYPE_B: size_type_b = cfg_data;
                    CFG_SIZE_TYPE_C: size_type_c = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata[OBJ_W-1:0]);
            if (m_tvalid && m_tready) begin
                if (picks_due.size() == 0)
                    report("result beat with nothing expected", m_tdata[63:0], 64'd0);
                else
                    check_pick({m_tuser[0], m_tuser[1], m_tdata[OBJ_W-1:0]});
            end
        end
        pending_count = picks_due.size();
    end

endmodule

// ----- tb/sv/priority_hit_test_table_tb.sv -----
`timescale 1ns / 1ps

module priority_hit_test_table_tb;
    import phtt_pkg::*;

    localparam int ITEM_TARGET = 1200;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;

    // Shape codes that the block must never report as hits.
    localparam logic [1:0] SHAPE_DEAD_LO = 2'd2;
    localparam logic [1:0] SHAPE_DEAD_HI = 2'd3;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic [1:0]        s_tuser   = OP_CLEAR;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_SIZE_TYPE_A;
    logic [5:0]        cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned items_sent   = 0;
    int unsigned idle_cycles  = 0;
    int          burst_left   = 0;
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;
    logic [5:0]  cfg_a        = 6'd0;
    logic [5:0]  cfg_b        = 6'd1;
    logic [5:0]  cfg_c        = 6'd2;
    logic [5:0]  plain_type   = 6'd9;

    priority_hit_test_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    priority_hit_test_table_checker pick_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: changes its stall pattern every so often, and on request
    // holds off for a long stretch so that the block backs up into its input.
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned stretch;
        mode = RX_OPEN;
        stretch = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (stretch == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    stretch = $urandom_range(20, 200);
                end
                stretch--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (stretch % 5 != 0);
                endcase
            end
        end
    end

    function automatic obj_t placed(input int x, input int y, input logic [5:0] kind,
                                    input logic [1:0] shape, input logic [9:0] size,
                                    input int mag);
        obj_t o;
        o.pos_x       = 16'(x);
        o.pos_y       = 16'(y);
        o.obj_type    = kind;
        o.hit_shape   = shape;
        o.obj_size    = size;
        o.magnitude   = 16'(mag);
        o.ra_word     = $urandom;
        o.dec_word    = $urandom;
        o.payload_one = {$urandom, $urandom};
        o.payload_two = {$urandom, $urandom};
        return o;
    endfunction

    function automatic obj_t probe(input int x, input int y);
        return placed(x, y, 6'($urandom), 2'($urandom), 10'($urandom), int'($urandom));
    endfunction

    // Objects scatter around a cluster center so that queries land on several at once.
    function automatic obj_t random_obj(input int cx, input int cy, input int spread,
                                        input bit wild);
        obj_t        o;
        int unsigned pick;
        o = placed(cx + int'($urandom_range(0, 2 * spread)) - spread,
                   cy + int'($urandom_range(0, 2 * spread)) - spread,
                   plain_type, SHAPE_CIRCLE, 10'd0, 0);
        if (wild) begin
            o.pos_x     = 16'($urandom);
            o.pos_y     = 16'($urandom);
            o.obj_type  = 6'($urandom);
            o.hit_shape = 2'($urandom);
            o.obj_size  = 10'($urandom);
            o.magnitude = 16'($urandom);
        end else begin
            case ($urandom_range(0, 5))
                0: o.obj_type = cfg_a;
                1: o.obj_type = cfg_b;
                2: o.obj_type = cfg_c;
                3: o.obj_type = 6'd63;
                default: o.obj_type = plain_type;
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 5)
                o.hit_shape = SHAPE_CIRCLE;
            else if (pick < 9)
                o.hit_shape = SHAPE_BOX;
            else
                o.hit_shape = $urandom_range(0, 1) ? SHAPE_DEAD_LO : SHAPE_DEAD_HI;
            o.obj_size = ($urandom_range(0, 15) == 0) ? 10'($urandom) :
                         10'($urandom_range(0, 24));
            case ($urandom_range(0, 5))
                0: o.magnitude = 16'sh8000;
                1: o.magnitude = 16'sh7fff;
                2: o.magnitude = -16'sd256;
                3: o.magnitude = 16'sd0;
                default: o.magnitude = 16'($urandom);
            endcase
        end
        return o;
    endfunction

    task automatic push_item(input logic [1:0] op, input obj_t item);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DATA_W - OBJ_W){1'b0}}, item};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op != OP_UNUSED) items_sent++;
        if (!steady && burst_left <= 0) begin
            burst_left = $urandom_range(0, 15);
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // Stops offering beats and waits until every result is in; a clear gives
    // no beat, so it then keeps waiting to let that finish as well.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_size_types(input logic [5:0] a, input logic [5:0] b,
                                  input logic [5:0] c);
        logic [5:0] vals [3];
        logic [1:0] idx  [3];
        int         k;
        vals = '{a, b, c};
        idx  = '{CFG_SIZE_TYPE_A, CFG_SIZE_TYPE_B, CFG_SIZE_TYPE_C};
        for (k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cfg_a = a;
        cfg_b = b;
        cfg_c = c;
    endtask

    initial begin : stimulus
        int phase;
        int cx;
        int cy;
        int spread;
        int fill;
        int queries;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_item(OP_QUERY, probe(0, 0));
        push_item(OP_APPEND, placed(0, 0, 6'd5, SHAPE_CIRCLE, 10'd0, 0));
        // The circle rim at size plus border still counts as a hit.
        push_item(OP_QUERY, probe(5, 0));
        push_item(OP_QUERY, probe(4, 4));
        push_item(OP_QUERY, probe(-3, -4));
        push_item(OP_APPEND, placed(100, 100, 6'd7, SHAPE_BOX, 10'd10, 0));
        push_item(OP_QUERY, probe(115, 85));
        push_item(OP_QUERY, probe(116, 100));
        push_item(OP_APPEND, placed(0, 0, 6'd0, SHAPE_DEAD_LO, 10'd50, 0));
        push_item(OP_APPEND, placed(0, 0, 6'd0, SHAPE_DEAD_HI, 10'd50, 0));
        push_item(OP_QUERY, probe(0, 0));
        // Same type and magnitude: the earlier of the two must win.
        push_item(OP_APPEND, placed(0, 0, 6'd5, SHAPE_CIRCLE, 10'd3, -256));
        push_item(OP_APPEND, placed(1, 0, 6'd5, SHAPE_BOX, 10'd1, -256));
        push_item(OP_QUERY, probe(0, 0));
        // Type 1 ranks by size out of reset, whatever the magnitudes say.
        push_item(OP_APPEND, placed(0, 0, 6'd1, SHAPE_CIRCLE, 10'd20, -32768));
        push_item(OP_APPEND, placed(1, 1, 6'd1, SHAPE_BOX, 10'd10, 32767));
        push_item(OP_APPEND, placed(0, 1, 6'd1, SHAPE_CIRCLE, 10'd10, -32768));
        push_item(OP_QUERY, probe(0, 0));
        push_item(OP_APPEND, placed(-32768, -32768, 6'd63, SHAPE_BOX, 10'd1023, -32768));
        push_item(OP_APPEND, placed(32767, 32767, 6'd63, SHAPE_CIRCLE, 10'd1023, 32767));
        push_item(OP_QUERY, probe(-32768, 32767));
        push_item(OP_QUERY, probe(32767, 32000));
        push_item(OP_QUERY, probe(-31740, -31740));
        push_item(OP_UNUSED, probe(0, 0));
        push_item(OP_CLEAR, probe(0, 0));
        push_item(OP_QUERY, probe(0, 0));

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case (phase)
                0: set_size_types(6'd63, 6'd63, 6'd63);
                1: set_size_types(6'd0, 6'd0, 6'd0);
                default: set_size_types(6'($urandom), 6'($urandom), 6'($urandom));
            endcase
            steady = (phase % 4 == 1);
            plain_type = 6'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                cx = $urandom_range(0, 1) ? 32760 : -32760;
                cy = $urandom_range(0, 1) ? 32760 : -32760;
            end else begin
                cx = int'($signed(16'($urandom)));
                cy = int'($signed(16'($urandom)));
            end
            spread = $urandom_range(2, 40);
            // One phase overfills the table so that dropped appends show up.
            fill = (phase == 3) ? $urandom_range(258, 262) : $urandom_range(1, 48);
            push_item(OP_CLEAR, random_obj(cx, cy, spread, 1'b1));
            for (n = 0; n < fill; n++) begin
                push_item(OP_APPEND, random_obj(cx, cy, spread, $urandom_range(0, 7) == 0));
                case ($urandom_range(0, 59))
                    0, 1: push_item(OP_UNUSED, random_obj(cx, cy, spread, 1'b1));
                    2: push_item(OP_CLEAR, random_obj(cx, cy, spread, 1'b1));
                    3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                        push_item(OP_QUERY, random_obj(cx, cy, spread + 10,
                                                       $urandom_range(0, 9) == 0));
                    default: ;
                endcase
            end
            if (phase == 2) hold_request = 1'b1;
            queries = $urandom_range(4, 20);
            for (n = 0; n < queries; n++)
                push_item(OP_QUERY, random_obj(cx, cy, spread + 10, $urandom_range(0, 9) == 0));
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
